// File: rtl/serial_frame_receiver_assert.svh
// Assertion macros for the serial frame receiver.
// Used by serial_frame_receiver.sv; compiled out when SYNTH is defined.
`ifndef SERIAL_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define SFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("serial_frame_receiver: assertion failed");
// Next-cycle implication, checked out of reset.
`define SFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("serial_frame_receiver: assertion failed");
`else
`define SFR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SFR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
// No dependencies; imported by sfr_core and serial_frame_receiver.
package sfr_pkg;

    localparam int BUFFER_BYTES         = 256;
    localparam int HEADER_TRAILER_BYTES = 7;
    localparam int LEN_CAP              = BUFFER_BYTES - HEADER_TRAILER_BYTES;
    localparam logic [7:0] LEN_CAP8     = (LEN_CAP > 255) ? 8'd255 : 8'(LEN_CAP);

    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [8:0] LEN_POS  = 9'd3;
    localparam logic [8:0] ADDR_POS = 9'd1;

    // item opcodes
    localparam logic [1:0] OP_BYTE     = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_LINE_ERR = 2'd2;

    // frame status codes
    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_GOOD     = 3'd1;
    localparam logic [2:0] ST_CSUM_BAD = 3'd2;
    localparam logic [2:0] ST_ADDR_BAD = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;
    localparam logic [2:0] ST_TIMEOUT  = 3'd5;
    localparam logic [2:0] ST_LINE_ERR = 3'd6;

    // config register indexes
    localparam logic [1:0] REG_MAX_LEN  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_EXP_ADDR = 2'd2;

    typedef struct packed {
        logic [7:0] max_data_len;
        logic [7:0] timeout_ticks;
        logic [7:0] expected_address;
    } sfr_cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } sfr_item_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic       last;
        logic [2:0] frame_status;
    } sfr_result_t;

endpackage

// File: rtl/sfr_core.sv
// Frame tracking state and per-item update for the serial frame receiver.
// Depends on sfr_pkg.
module sfr_core
    import sfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  sfr_cfg_t    cfg,
    input  logic        fire,
    input  sfr_item_t   item,
    output logic        has_result,
    output sfr_result_t result
);

    typedef enum logic [1:0] {PH_IDLE, PH_HEAD, PH_DATA} phase_t;

    phase_t     phase_reg, phase_next;
    logic [8:0] count_reg, count_next;
    logic [8:0] total_reg, total_next;
    logic [7:0] ticks_reg, ticks_next;
    logic [7:0] sum_reg,   sum_next;
    logic       match_reg, match_next;

    logic [7:0] limit;
    logic [7:0] ticks_inc;
    logic [7:0] sum_data;
    logic [9:0] pos_p1;
    logic [9:0] pos_p2;
    logic [9:0] total_w;

    assign limit     = (cfg.max_data_len < LEN_CAP8) ? cfg.max_data_len : LEN_CAP8;
    assign ticks_inc = (ticks_reg == 8'hFF) ? ticks_reg : ticks_reg + 8'd1;
    assign pos_p1    = {1'b0, count_reg} + 10'd1;
    assign pos_p2    = {1'b0, count_reg} + 10'd2;
    assign total_w   = {1'b0, total_reg};

    // checksum byte is subtracted so a match leaves zero
    always_comb begin
        if (pos_p2 < total_w) begin
            sum_data = sum_reg + item.rx_byte;
        end else if (pos_p2 == total_w) begin
            sum_data = sum_reg - item.rx_byte;
        end else begin
            sum_data = sum_reg;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        total_next = total_reg;
        ticks_next = ticks_reg;
        sum_next   = sum_reg;
        match_next = match_reg;
        has_result = 1'b0;
        result     = '{byte_value: item.rx_byte, byte_index: count_reg[7:0],
                       last: 1'b0, frame_status: ST_BUSY};

        unique case (phase_reg)
            PH_IDLE: begin
                if (item.op == OP_BYTE && item.rx_byte == STX_BYTE) begin
                    phase_next = PH_HEAD;
                    count_next = 9'd1;
                    total_next = '0;
                    ticks_next = '0;
                    sum_next   = item.rx_byte;
                    match_next = 1'b0;
                    has_result = 1'b1;
                    result.byte_index = 8'd0;
                end
            end
            PH_HEAD, PH_DATA: begin
                case (item.op)
                    OP_TICK: begin
                        ticks_next = ticks_inc;
                        if (ticks_inc > cfg.timeout_ticks) begin
                            has_result          = 1'b1;
                            result.byte_value   = '0;
                            result.last         = 1'b1;
                            result.frame_status = ST_TIMEOUT;
                        end
                    end
                    OP_LINE_ERR: begin
                        has_result          = 1'b1;
                        result.byte_value   = '0;
                        result.last         = 1'b1;
                        result.frame_status = ST_LINE_ERR;
                    end
                    OP_BYTE: begin
                        has_result = 1'b1;
                        count_next = pos_p1[8:0];
                        if (phase_reg == PH_HEAD) begin
                            sum_next = sum_reg + item.rx_byte;
                            if (count_reg == ADDR_POS) begin
                                match_next = (item.rx_byte == cfg.expected_address);
                            end
                            if (count_reg == LEN_POS) begin
                                if (item.rx_byte > limit) begin
                                    result.last         = 1'b1;
                                    result.frame_status = ST_TOO_LONG;
                                end else begin
                                    total_next = {1'b0, item.rx_byte}
                                               + 9'(HEADER_TRAILER_BYTES);
                                    phase_next = PH_DATA;
                                    ticks_next = '0;
                                end
                            end
                        end else begin
                            ticks_next = '0;
                            sum_next   = sum_data;
                            if (pos_p1 >= total_w) begin
                                result.last = 1'b1;
                                if (sum_data != 8'd0) begin
                                    result.frame_status = ST_CSUM_BAD;
                                end else if (!match_reg) begin
                                    result.frame_status = ST_ADDR_BAD;
                                end else begin
                                    result.frame_status = ST_GOOD;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                // any frame end returns to idle with cleared state
                if (has_result && result.last) begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                    total_next = '0;
                    ticks_next = '0;
                    sum_next   = '0;
                    match_next = 1'b0;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            ticks_reg <= '0;
            sum_reg   <= '0;
            match_reg <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            total_reg <= total_next;
            ticks_reg <= ticks_next;
            sum_reg   <= sum_next;
            match_reg <= match_next;
        end
    end

endmodule

// File: rtl/serial_frame_receiver.sv
// Serial frame receiver: an accepted item passes through the input register,
// then the frame update into the result register.
// Throughput 1 item per cycle; the input register keeps taking items while
// a result waits, and stalls only when both stages are full.
// Synchronous active-low reset returns to waiting for STX with config at
// max_data_len 249, timeout_ticks 20, expected_address 0.
module serial_frame_receiver
    import sfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_byte_value,
    output logic [7:0] m_byte_index,
    output logic       m_last,
    output logic [2:0] m_frame_status
);

`include "serial_frame_receiver_assert.svh"

    sfr_cfg_t    cfg_reg;
    logic        in_valid_reg;
    sfr_item_t   in_item_reg;
    logic        out_valid_reg;
    sfr_result_t out_reg;

    logic        fire;
    logic        has_result;
    sfr_result_t result;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{max_data_len: 8'd249, timeout_ticks: 8'd20,
                         expected_address: 8'd0};
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAX_LEN:  cfg_reg.max_data_len     <= cfg_wr_data;
                REG_TIMEOUT:  cfg_reg.timeout_ticks    <= cfg_wr_data;
                REG_EXP_ADDR: cfg_reg.expected_address <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{op: s_op, rx_byte: s_rx_byte};
        end
    end

    sfr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .fire       (fire),
        .item       (in_item_reg),
        .has_result (has_result),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && has_result) begin
            out_reg <= result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_byte_value   = out_reg.byte_value;
    assign m_byte_index   = out_reg.byte_index;
    assign m_last         = out_reg.last;
    assign m_frame_status = out_reg.frame_status;

    `SFR_ASSERT_IMP(a_busy_not_last, aclk, aresetn, m_valid && !m_last, m_frame_status == ST_BUSY)
    `SFR_ASSERT_IMP(a_last_has_verdict, aclk, aresetn, m_valid && m_last, m_frame_status != ST_BUSY)
    `SFR_ASSERT_IMP(a_full_stalls, aclk, aresetn, in_valid_reg && out_valid_reg && !m_ready, !s_ready)
    `SFR_ASSERT_NXT(a_held_item_kept, aclk, aresetn, in_valid_reg && !fire, in_valid_reg)

endmodule
